// ----- src/artsel_pkg.sv -----
package artsel_pkg;

    // default table size
    localparam int SLOTS_DEF = 16;

    // command codes
    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_RELEASE = 3'd1;
    localparam logic [2:0] CMD_UPDATE  = 3'd2;
    localparam logic [2:0] CMD_TICK    = 3'd3;
    localparam logic [2:0] CMD_SELECT  = 3'd4;

    // outcome codes
    localparam logic [1:0] OUT_DONE    = 2'd0;
    localparam logic [1:0] OUT_NO_FREE = 2'd1;
    localparam logic [1:0] OUT_NO_USED = 2'd2;

    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    typedef logic [3:0] quiet_t;

    // input beat
    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  slot;
        logic [3:0]  new_status;
        logic [7:0]  new_priority;
        logic [15:0] new_age;
    } in_item_t;

    // result beat
    typedef struct packed {
        logic [1:0]  outcome;
        logic [3:0]  chosen_slot;
        logic [16:0] best_rank;
    } out_item_t;

    // one table entry as stored in the slot memory
    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  prio;
        logic [15:0] age;
    } slot_entry_t;

endpackage

// ----- src/artsel_ram.sv -----
module artsel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/aging_rank_task_selector.sv -----
// Release, update and unknown commands go through the exec state; allocate scans the
// in-use bits one slot per cycle and stops at the first free slot; tick and select do one
// slot memory read per cycle into a 4-stage read / square / multiply / compare pipeline.
// Throughput: one command in flight; the next is accepted at the end of the first cycle
// its result is offered.
// Async reset clears in-use bits, quiet_level and control; allocate zeroes its slot entry.
module aging_rank_task_selector #(
    parameter int SLOTS = artsel_pkg::SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 task_valid,
    output logic                 task_stall,
    input  artsel_pkg::in_item_t task_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output artsel_pkg::out_item_t result_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  artsel_pkg::quiet_t   cfg_data
);

    import artsel_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int ENT_W = $bits(slot_entry_t);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          item_reg;
    quiet_t            quiet_reg;
    logic [SLOTS-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [16:0]       best_reg, best_next;

    logic              result_valid_reg;
    out_item_t         result_reg;

    // scan pipeline
    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [IDX_W-1:0]  p1_idx_reg, p2_idx_reg, p3_idx_reg;
    logic              p1_used_reg, p2_used_reg, p3_used_reg;
    logic [7:0]        p2_sq_reg;
    logic [7:0]        p2_prio_reg;
    logic [15:0]       p2_age_reg, p3_age_reg;
    logic [15:0]       p3_prod_reg;

    // memory port signals
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    slot_entry_t       ram_wdata;
    slot_entry_t       ram_rdata;
    logic [ENT_W-1:0]  ram_rdata_raw;

    logic              accept;
    logic              slot_ok;
    logic [IDX_W-1:0]  slot_idx;
    logic              is_scan_cmd;
    logic              alloc_hit;
    logic              tick_wb;
    logic [16:0]       p3_rank;
    logic              out_free;
    out_item_t         result_next;

    assign accept      = task_valid && !task_stall;
    assign task_stall  = (state_reg != ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_free    = !result_valid_reg || !result_stall;
    assign slot_ok     = (int'(item_reg.slot) < SLOTS);
    assign slot_idx    = IDX_W'(item_reg.slot);
    assign is_scan_cmd = (item_reg.command == CMD_TICK) || (item_reg.command == CMD_SELECT);
    assign alloc_hit   = (state_reg == ST_SCAN) && (item_reg.command == CMD_ALLOC)
                         && !used_reg[cnt_reg];
    assign ram_rdata   = slot_entry_t'(ram_rdata_raw);

    // tick write-back happens in the cycle after the read
    assign tick_wb = p1_valid_reg && p1_used_reg && (item_reg.command == CMD_TICK)
                     && (ram_rdata.status > quiet_reg) && (ram_rdata.age != AGE_MAX);

    assign p3_rank = {1'b0, p3_prod_reg} + {1'b0, p3_age_reg};

    artsel_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (cnt_reg),
        .rd_data (ram_rdata_raw)
    );

    // memory write select
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = '0;
        if (state_reg == ST_EXEC && item_reg.command == CMD_UPDATE && slot_ok
            && used_reg[slot_idx])
        begin
            ram_we           = 1'b1;
            ram_waddr        = slot_idx;
            ram_wdata.status = item_reg.new_status;
            ram_wdata.prio   = item_reg.new_priority;
            ram_wdata.age    = item_reg.new_age;
        end
        else if (alloc_hit)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
        end
        else if (tick_wb)
        begin
            ram_we        = 1'b1;
            ram_waddr     = p1_idx_reg;
            ram_wdata     = ram_rdata;
            ram_wdata.age = ram_rdata.age + 16'd1;
        end
    end

    // control state machine
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    found_next = 1'b0;
                    best_next  = '0;
                    if (task_data.command == CMD_ALLOC || task_data.command == CMD_TICK
                        || task_data.command == CMD_SELECT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (item_reg.command == CMD_RELEASE && slot_ok)
                begin
                    used_next[slot_idx] = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (alloc_hit)
                begin
                    used_next[cnt_reg] = 1'b1;
                    found_next         = 1'b1;
                    best_idx_next      = cnt_reg;
                    state_next         = ST_DONE;
                end
                else if (cnt_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = is_scan_cmd ? ST_DRAIN : ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // rank compare at the end of the select pipeline
        if (p3_valid_reg && p3_used_reg && item_reg.command == CMD_SELECT
            && (!found_reg || p3_rank > best_reg))
        begin
            found_next    = 1'b1;
            best_next     = p3_rank;
            best_idx_next = p3_idx_reg;
        end
    end

    // result composition
    always_comb
    begin
        result_next = '0;
        result_next.outcome = OUT_DONE;
        if (item_reg.command == CMD_ALLOC)
        begin
            if (found_reg)
            begin
                result_next.chosen_slot = 4'(best_idx_reg);
            end
            else
            begin
                result_next.outcome = OUT_NO_FREE;
            end
        end
        else if (item_reg.command == CMD_SELECT)
        begin
            if (found_reg)
            begin
                result_next.chosen_slot = 4'(best_idx_reg);
                result_next.best_rank   = best_reg;
            end
            else
            begin
                result_next.outcome = OUT_NO_USED;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            used_reg         <= '0;
            quiet_reg        <= '0;
            cnt_reg          <= '0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p3_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            cnt_reg      <= cnt_next;
            found_reg    <= found_next;
            p1_valid_reg <= (state_reg == ST_SCAN) && is_scan_cmd;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (cfg_valid && cfg_ready)
            begin
                quiet_reg <= cfg_data;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        if (accept)
        begin
            item_reg <= task_data;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            result_reg <= result_next;
        end
        // read stage bookkeeping
        p1_idx_reg  <= cnt_reg;
        p1_used_reg <= used_reg[cnt_reg];
        // square stage
        p2_idx_reg  <= p1_idx_reg;
        p2_used_reg <= p1_used_reg;
        p2_sq_reg   <= {4'b0, ram_rdata.status} * {4'b0, ram_rdata.status};
        p2_prio_reg <= ram_rdata.prio;
        p2_age_reg  <= ram_rdata.age;
        // multiply stage
        p3_idx_reg  <= p2_idx_reg;
        p3_used_reg <= p2_used_reg;
        p3_prod_reg <= {8'b0, p2_sq_reg} * {8'b0, p2_prio_reg};
        p3_age_reg  <= p2_age_reg;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

`ifndef ASSERT_OFF
    // tick write-back never hits the entry being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == ST_SCAN && item_reg.command == CMD_TICK)
        |-> (ram_waddr != cnt_reg))
        else $error("tick write-back collides with scan read");

    // the scan pipeline is empty whenever a new command can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg))
        else $error("scan pipeline busy while idle");

    // a claimed slot is marked in use on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        alloc_hit |=> used_reg[$past(cnt_reg)])
        else $error("allocated slot not marked in use");

    // a new result appears only out of the delivery state
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && $past(!result_valid_reg)) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside delivery");

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
`endif

endmodule
